// ===== hdl/pst_pkg.sv =====
package pst_pkg;

    localparam int SLOTS           = 16;
    localparam int MEM_PER_PROCESS = 1024;
    localparam int IDX_W           = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [15:0] FIRST_PID = 16'd1000;
    localparam logic [3:0]  MAX_PRIO  = 4'd9;

    localparam logic [2:0] CMD_CREATE    = 3'd0;
    localparam logic [2:0] CMD_TERMINATE = 3'd1;
    localparam logic [2:0] CMD_BLOCK     = 3'd2;
    localparam logic [2:0] CMD_UNBLOCK   = 3'd3;
    localparam logic [2:0] CMD_FIND      = 3'd4;

    localparam logic [1:0] RES_DONE      = 2'd0;
    localparam logic [1:0] RES_FULL      = 2'd1;
    localparam logic [1:0] RES_MISSING   = 2'd2;
    localparam logic [1:0] RES_UNCHANGED = 2'd3;

    localparam logic [2:0] PS_NEW        = 3'd0;
    localparam logic [2:0] PS_READY      = 3'd1;
    localparam logic [2:0] PS_RUNNING    = 3'd2;
    localparam logic [2:0] PS_BLOCKED    = 3'd3;
    localparam logic [2:0] PS_TERMINATED = 3'd4;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [15:0]       pid;
        logic signed [7:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pid_out;
        logic [3:0]  slot;
        logic [2:0]  proc_state;
        logic [3:0]  priority_out;
        logic [13:0] mem_base;
    } rsp_t;

    // command walking the cell row
    typedef struct packed {
        logic        valid;
        logic        done;
        logic [2:0]  cmd;
        logic [15:0] pid;
        logic [3:0]  prio;
        rsp_t        res;
    } tok_t;

    function automatic logic [3:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[3:0];
    endfunction

    function automatic logic [13:0] base_of(input logic [IDX_W-1:0] idx);
        logic [31:0] p;
        p = 32'(idx) * MEM_PER_PROCESS;
        return p[13:0];
    endfunction

endpackage

// ===== hdl/pst_cell.sv =====
module pst_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pst_pkg::IDX_W-1:0]  index,
    input  logic                       hold,
    input  pst_pkg::tok_t              tok_in,
    output pst_pkg::tok_t              tok_out
);
    import pst_pkg::*;

    logic        used_reg;
    logic        used_next;
    logic [15:0] pid_reg;
    logic [15:0] pid_next;
    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [3:0]  prio_reg;
    logic [3:0]  prio_next;
    tok_t        tok_reg;
    tok_t        tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        used_next  = used_reg;
        pid_next   = pid_reg;
        state_next = state_reg;
        prio_next  = prio_reg;
        if (tok_in.valid && !tok_in.done)
        begin
            if (tok_in.cmd == CMD_CREATE)
            begin
                if (!used_reg)
                begin
                    used_next                 = 1'b1;
                    pid_next                  = tok_in.pid;
                    state_next                = PS_READY;
                    prio_next                 = tok_in.prio;
                    tok_next.done             = 1'b1;
                    tok_next.res.status       = RES_DONE;
                    tok_next.res.pid_out      = tok_in.pid;
                    tok_next.res.slot         = slot_of(index);
                    tok_next.res.proc_state   = PS_READY;
                    tok_next.res.priority_out = tok_in.prio;
                    tok_next.res.mem_base     = base_of(index);
                end
            end
            else if (used_reg && (pid_reg == tok_in.pid))
            begin
                tok_next.done             = 1'b1;
                tok_next.res.status       = RES_DONE;
                tok_next.res.pid_out      = pid_reg;
                tok_next.res.slot         = slot_of(index);
                tok_next.res.proc_state   = state_reg;
                tok_next.res.priority_out = prio_reg;
                tok_next.res.mem_base     = base_of(index);
                case (tok_in.cmd)
                    CMD_TERMINATE:
                    begin
                        used_next               = 1'b0;
                        state_next              = PS_TERMINATED;
                        tok_next.res.proc_state = PS_TERMINATED;
                    end
                    CMD_BLOCK:
                    begin
                        if ((state_reg == PS_READY) || (state_reg == PS_RUNNING))
                        begin
                            state_next              = PS_BLOCKED;
                            tok_next.res.proc_state = PS_BLOCKED;
                        end
                        else
                        begin
                            tok_next.res.status = RES_UNCHANGED;
                        end
                    end
                    CMD_UNBLOCK:
                    begin
                        if (state_reg == PS_BLOCKED)
                        begin
                            state_next              = PS_READY;
                            tok_next.res.proc_state = PS_READY;
                        end
                        else
                        begin
                            tok_next.res.status = RES_UNCHANGED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else if (!hold)
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            pid_reg   <= pid_next;
            state_reg <= state_next;
            prio_reg  <= prio_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/process_slot_table.sv =====
// Process slot table: each command item walks a row of SLOTS cells, one slot per
// cycle, and the first free slot (create) or the first live slot holding the id
// (terminate, block, unblock, find) acts on it, so the lowest slot always wins.
// The result passes from the last cell into the output register; a new command is
// accepted once the previous result has reached the output register, so the block
// takes no new command while one is still walking the cell row. Unknown commands
// report no change with all fields zero; the id counter starts at 1000 and wraps
// at 16 bits.
module process_slot_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pst_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pst_pkg::rsp_t  rsp
);
    import pst_pkg::*;

    tok_t        chain [SLOTS+1];
    tok_t        tail;
    logic        busy_reg;
    logic        busy_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic [15:0] next_pid_reg;
    logic [15:0] next_pid_next;
    logic        accept;
    logic        load;
    logic        hold;
    logic [3:0]  prio_clamped;

    assign req_ready = !busy_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        if (req.priority_req[7])
        begin
            prio_clamped = 4'd0;
        end
        else if (req.priority_req[6:0] > 7'(MAX_PRIO))
        begin
            prio_clamped = MAX_PRIO;
        end
        else
        begin
            prio_clamped = req.priority_req[3:0];
        end
    end

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = accept;
        chain[0].cmd   = req.cmd;
        chain[0].pid   = (req.cmd == CMD_CREATE) ? next_pid_reg : req.pid;
        chain[0].prio  = prio_clamped;
        if (req.cmd > CMD_FIND)
        begin
            chain[0].done       = 1'b1;
            chain[0].res.status = RES_UNCHANGED;
        end
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        pst_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (IDX_W'(i)),
            .hold    (hold),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign tail = chain[SLOTS];
    assign load = tail.valid && (!rsp_valid_reg || rsp_ready);
    assign hold = tail.valid && !load;

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        busy_next      = busy_reg;
        next_pid_next  = next_pid_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (load)
        begin
            rsp_valid_next = 1'b1;
            busy_next      = 1'b0;
            if (tail.done)
            begin
                rsp_next = tail.res;
                if (tail.cmd == CMD_CREATE)
                begin
                    next_pid_next = tail.pid + 16'd1;
                end
            end
            else if (tail.cmd == CMD_CREATE)
            begin
                rsp_next        = '0;
                rsp_next.status = RES_FULL;
            end
            else
            begin
                rsp_next         = '0;
                rsp_next.status  = RES_MISSING;
                rsp_next.pid_out = tail.pid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            next_pid_reg  <= FIRST_PID;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            next_pid_reg  <= next_pid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/sv/process_slot_table_tb.sv =====
module process_slot_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 12_000_000;

    class slot_table_shadow;
        bit          live [SLOTS];
        logic [15:0] owner_pid [SLOTS];
        logic [2:0]  proc_st [SLOTS];
        logic [3:0]  prio [SLOTS];
        logic [15:0] next_id;
        rsp_t        awaited[$];
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned outcome_count [4];

        function new();
            foreach (live[i])
            begin
                live[i]      = 1'b0;
                owner_pid[i] = '0;
                proc_st[i]   = PS_NEW;
                prio[i]      = '0;
            end
            next_id = FIRST_PID;
        endfunction

        function rsp_t slot_view(logic [1:0] status, int s);
            rsp_t        v;
            int unsigned base;
            base           = s * MEM_PER_PROCESS;
            v.status       = status;
            v.pid_out      = owner_pid[s];
            v.slot         = 4'(s);
            v.proc_state   = proc_st[s];
            v.priority_out = prio[s];
            v.mem_base     = 14'(base);
            return v;
        endfunction

        function void note_command(req_t r);
            rsp_t       want;
            int         s;
            logic [7:0] raw;
            logic [1:0] outcome;
            want = '0;
            s    = SLOTS;
            case (r.cmd)
                CMD_CREATE:
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!live[i])
                            s = i;
                    if (s == SLOTS)
                        want.status = RES_FULL;
                    else
                    begin
                        raw = r.priority_req;
                        live[s]      = 1'b1;
                        owner_pid[s] = next_id;
                        proc_st[s]   = PS_READY;
                        if (raw[7])
                            prio[s] = '0;
                        else if (raw > MAX_PRIO)
                            prio[s] = MAX_PRIO;
                        else
                            prio[s] = raw[3:0];
                        next_id = next_id + 16'd1;
                        want    = slot_view(RES_DONE, s);
                    end
                end
                CMD_TERMINATE, CMD_BLOCK, CMD_UNBLOCK, CMD_FIND:
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (live[i] && owner_pid[i] == r.pid)
                            s = i;
                    if (s == SLOTS)
                    begin
                        want.status  = RES_MISSING;
                        want.pid_out = r.pid;
                    end
                    else
                    begin
                        outcome = RES_DONE;
                        case (r.cmd)
                            CMD_TERMINATE:
                            begin
                                proc_st[s] = PS_TERMINATED;
                                live[s]    = 1'b0;
                            end
                            CMD_BLOCK:
                                if (proc_st[s] == PS_READY || proc_st[s] == PS_RUNNING)
                                    proc_st[s] = PS_BLOCKED;
                                else
                                    outcome = RES_UNCHANGED;
                            CMD_UNBLOCK:
                                if (proc_st[s] == PS_BLOCKED)
                                    proc_st[s] = PS_READY;
                                else
                                    outcome = RES_UNCHANGED;
                            default: ;
                        endcase
                        want = slot_view(outcome, s);
                    end
                end
                default:
                    want.status = RES_UNCHANGED;
            endcase
            awaited.push_back(want);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: status %0d pid %0d slot %0d",
                             $realtime, got.status, got.pid_out, got.slot);
                return;
            end
            want = awaited.pop_front();
            results_checked++;
            outcome_count[want.status]++;
            if (got.status !== want.status || got.pid_out !== want.pid_out ||
                got.slot !== want.slot || got.proc_state !== want.proc_state ||
                got.priority_out !== want.priority_out || got.mem_base !== want.mem_base)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result %0d mismatch", $realtime, results_checked);
                    $display("  expected status %0d pid %0d slot %0d state %0d prio %0d base %0d",
                             want.status, want.pid_out, want.slot, want.proc_state,
                             want.priority_out, want.mem_base);
                    $display("  actual   status %0d pid %0d slot %0d state %0d prio %0d base %0d",
                             got.status, got.pid_out, got.slot, got.proc_state,
                             got.priority_out, got.mem_base);
                end
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    slot_table_shadow sb;
    int               s_idle = 19;
    int               r_idle = 77;
    int unsigned      cycles = 0;
    int unsigned      items_sent = 0;

    process_slot_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= r_idle);

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.awaited.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic req_t pack_cmd(logic [2:0] cmd, logic [15:0] pid, int p);
        req_t r;
        r.cmd          = cmd;
        r.pid          = pid;
        r.priority_req = 8'(p);
        return r;
    endfunction

    task automatic send_item(input req_t item);
        while ($urandom_range(99) < s_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_command(item);
        items_sent++;
    endtask

    task automatic run_random(input int count, input int snd_idle, input int rcv_idle);
        req_t        item;
        logic [15:0] held[$];
        int          pick;
        int          create_share;
        s_idle = snd_idle;
        r_idle = rcv_idle;
        for (int n = 0; n < count; n++)
        begin
            held.delete();
            for (int i = 0; i < SLOTS; i++)
                if (sb.live[i])
                    held.push_back(sb.owner_pid[i]);
            // alternate filling and draining the table
            create_share = ((n / 48) % 2) ? 50 : 12;
            pick = $urandom_range(99);
            item.priority_req = 8'($urandom);
            if (pick < create_share)
                item.cmd = CMD_CREATE;
            else if (pick >= 96)
                item.cmd = 3'(CMD_FIND + 1 + $urandom_range(2));
            else
                item.cmd = 3'($urandom_range(CMD_FIND, CMD_TERMINATE));
            pick = $urandom_range(99);
            if (pick < 75 && held.size() > 0)
                item.pid = held[$urandom_range(held.size() - 1)];
            else if (pick < 88)
                item.pid = 16'(sb.next_id - 1 - $urandom_range(7));
            else
                item.pid = 16'($urandom);
            send_item(item);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clamping at both ends of the signed range
        send_item(pack_cmd(CMD_CREATE, 16'hFFFF, -128));
        send_item(pack_cmd(CMD_CREATE, 16'h0000, 127));
        send_item(pack_cmd(CMD_CREATE, 16'h5A5A, 9));
        send_item(pack_cmd(CMD_CREATE, 16'hA5A5, 10));
        send_item(pack_cmd(CMD_CREATE, 16'h0001, 5));
        send_item(pack_cmd(CMD_FIND, FIRST_PID, 0));
        send_item(pack_cmd(CMD_BLOCK, FIRST_PID, 0));
        send_item(pack_cmd(CMD_BLOCK, FIRST_PID, 0));
        send_item(pack_cmd(CMD_UNBLOCK, FIRST_PID, 0));
        send_item(pack_cmd(CMD_UNBLOCK, FIRST_PID, 0));
        send_item(pack_cmd(CMD_TERMINATE, FIRST_PID + 16'd1, 0));
        send_item(pack_cmd(CMD_FIND, FIRST_PID + 16'd1, 0));
        send_item(pack_cmd(CMD_BLOCK, 16'hFFFF, 0));
        send_item(pack_cmd(CMD_TERMINATE, 16'h0000, 0));
        send_item(pack_cmd(CMD_CREATE, 16'h1234, 0));
        send_item(pack_cmd(3'(CMD_FIND + 1), FIRST_PID, -1));
        send_item(pack_cmd(3'(CMD_FIND + 2), FIRST_PID, 1));
        send_item(pack_cmd(3'(CMD_FIND + 3), FIRST_PID, 127));
        // fill the table, then one create too many
        for (int k = 0; k <= SLOTS - 5; k++)
            send_item(pack_cmd(CMD_CREATE, 16'(k * 4099), k - 3));

        run_random(384, 19, 77);
        run_random(384, 77, 19);
        run_random(384, 0, 0);
        req_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 4) @(posedge clk);

        $display("%0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, sb.results_checked, sb.mismatches);
        $display("outcomes: done %0d, table full %0d, id missing %0d, no change %0d",
                 sb.outcome_count[RES_DONE], sb.outcome_count[RES_FULL],
                 sb.outcome_count[RES_MISSING], sb.outcome_count[RES_UNCHANGED]);
        if (sb.awaited.size() != 0)
            $display("%0d expected results never arrived", sb.awaited.size());
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
